>>> rtl/core/bhfa_pkg.sv
// Package for the bird's-eye homography unit: item types, fixed-point constants,
// the whole-degree sine ROM and rounding helpers. No dependencies.
package bhfa_pkg;

    localparam int TRIG_FRAC     = 30;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_W         = 48;
    localparam int DEG_ZERO      = 90;
    localparam int DEG_MAX       = 180;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [7:0]  tilt_x_deg;
        logic [7:0]  tilt_y_deg;
        logic [7:0]  tilt_z_deg;
        logic [10:0] focal_length;
        logic [10:0] camera_distance;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] row0_col0;
        logic signed [OUT_W-1:0] row0_col1;
        logic signed [OUT_W-1:0] row0_col2;
        logic signed [OUT_W-1:0] row1_col0;
        logic signed [OUT_W-1:0] row1_col1;
        logic signed [OUT_W-1:0] row1_col2;
        logic signed [OUT_W-1:0] row2_col0;
        logic signed [OUT_W-1:0] row2_col1;
        logic signed [OUT_W-1:0] row2_col2;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_trig;

    typedef logic [90:0][31:0] t_sine_rom;

    // Q30 sine of 0..90 degrees by an eight-term Taylor series
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom        rom;
        logic [63:0]      x;
        logic [63:0]      x2;
        logic [63:0]      t;
        logic signed [63:0] s;
        for (int d = 0; d <= 90; d++) begin
            x  = (64'(d) * 64'd31415926 * (64'd1 << TRIG_FRAC) + 64'd900000000)
                 / 64'd1800000000;
            x2 = (x * x) >> TRIG_FRAC;
            s  = $signed(x);
            t  = ((x * x2) >> TRIG_FRAC) / 64'd6;   s = s - $signed(t);
            t  = ((t * x2) >> TRIG_FRAC) / 64'd20;  s = s + $signed(t);
            t  = ((t * x2) >> TRIG_FRAC) / 64'd42;  s = s - $signed(t);
            t  = ((t * x2) >> TRIG_FRAC) / 64'd72;  s = s + $signed(t);
            t  = ((t * x2) >> TRIG_FRAC) / 64'd110; s = s - $signed(t);
            t  = ((t * x2) >> TRIG_FRAC) / 64'd156; s = s + $signed(t);
            t  = ((t * x2) >> TRIG_FRAC) / 64'd210; s = s - $signed(t);
            rom[d] = s[31:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // floor((v + 2^(n-1)) / 2^n)
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int n);
        logic signed [63:0] half;
        half = 64'sd1 <<< (n - 1);
        return (v + half) >>> n;
    endfunction

endpackage

>>> rtl/core/bhfa_in_if.sv
// Input channel of the homography unit: valid/ready plus one angle/lens item.
// Depends on bhfa_pkg.
interface bhfa_in_if import bhfa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/bhfa_out_if.sv
// Output channel of the homography unit: valid/ready plus one matrix item.
// Depends on bhfa_pkg.
interface bhfa_out_if import bhfa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/birdseye_homography_from_angles_unit.sv
// Bird's-eye homography H = K*T*(Rx*Ry*Rz)*A1 from tilt angles, nine-stage pipeline.
// Depends on bhfa_pkg, bhfa_in_if, bhfa_out_if.
//
//   channel   dir  width  content
//   i_item    in   46     three tilt angles, focal length, camera distance
//   o_result  out  433    nine Q(47-F).F entries and a saturation flag
//   i_cfg_*   in   2+13   image width (index 0), image height (index 1)
//
// Nine register stages; one transfer per cycle while the output is not stalled.
// The multiplier stages are each fully pipelined and do not hold the rate.
// Synchronous active-low reset clears valid bits and sets 1280 x 720.
// A stalled output holds the whole pipeline; input ready follows that stall.
module birdseye_homography_from_angles_unit import bhfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bhfa_in_if.sink              i_item,
    bhfa_out_if.source           o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SH = TRIG_FRAC - FRAC_BITS;

    logic [CFG_W-1:0] r_width, r_height;
    logic [11:0]      w_w2, w_h2;
    logic             w_adv;
    logic [9:1]       r_vld;

    function automatic t_trig trig_of(input logic [7:0] raw);
        logic [7:0] d;
        logic [6:0] mag;
        t_trig      t;
        d   = (raw > 8'(DEG_MAX)) ? 8'(DEG_MAX) : raw;
        mag = (d >= 8'(DEG_ZERO)) ? 7'(d - 8'(DEG_ZERO)) : 7'(8'(DEG_ZERO) - d);
        t.s = (d < 8'(DEG_ZERO)) ? -$signed(SINE_ROM[mag]) : $signed(SINE_ROM[mag]);
        t.c = $signed(SINE_ROM[7'(7'd90 - mag)]);
        return t;
    endfunction

    function automatic logic signed [OUT_W:0] finish(input logic signed [63:0] q);
        logic signed [63:0] v;
        logic               sat;
        v   = rnd_shift(q, SH);
        sat = 1'b0;
        if (v > OUT_MAX) begin
            v   = OUT_MAX;
            sat = 1'b1;
        end else if (v < OUT_MIN) begin
            v   = OUT_MIN;
            sat = 1'b1;
        end
        return {v[OUT_W-1:0], sat};
    endfunction

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1280);
            r_height <= CFG_W'(720);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_w2  = r_width[CFG_W-1:1];
    assign w_h2  = r_height[CFG_W-1:1];
    assign w_adv = !r_vld[9] || o_result.ready;
    assign i_item.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[8:1], i_item.valid};
        end
    end

    // stage payloads
    t_trig                r1_x, r1_y, r1_z;
    logic [10:0]          r1_f, r1_d, r2_f, r2_d, r3_f, r3_d, r4_f, r4_d;
    logic [10:0]          r5_f, r5_d, r6_f, r6_d, r7_f;
    logic signed [63:0]   r2_m1, r2_m2;
    logic signed [31:0]   r2_cb, r2_ca, r2_sa, r2_cg, r2_sg;
    logic signed [31:0]   r3_p [3];
    logic signed [31:0]   r3_q [3];
    logic signed [31:0]   r3_cg, r3_sg;
    logic signed [63:0]   r4_pc [3];
    logic signed [63:0]   r4_qs [3];
    logic signed [63:0]   r4_qc [3];
    logic signed [63:0]   r4_ps [3];
    logic signed [33:0]   r5_r0 [3];
    logic signed [33:0]   r5_r1 [3];
    logic signed [47:0]   r6_wr [3];
    logic signed [47:0]   r6_hr [3];
    logic signed [33:0]   r6_r0 [3];
    logic signed [33:0]   r6_r1 [3];
    logic signed [47:0]   r7_b [3][3];
    logic signed [63:0]   r8_fa [3];
    logic signed [63:0]   r8_wa [3];
    logic signed [63:0]   r8_fb [3];
    logic signed [63:0]   r8_hb [3];
    logic signed [63:0]   r8_c [3];
    t_out_item            r9_out;
    logic signed [OUT_W:0] n_e [9];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // 1: ROM lookups
            r1_x <= trig_of(i_item.data.tilt_x_deg);
            r1_y <= trig_of(i_item.data.tilt_y_deg);
            r1_z <= trig_of(i_item.data.tilt_z_deg);
            r1_f <= i_item.data.focal_length;
            r1_d <= i_item.data.camera_distance;
            // 2: Rx*Ry products
            r2_m1 <= r1_x.s * r1_y.s;
            r2_m2 <= r1_x.c * r1_y.s;
            r2_cb <= r1_y.c;
            r2_ca <= r1_x.c;
            r2_sa <= r1_x.s;
            r2_cg <= r1_z.c;
            r2_sg <= r1_z.s;
            r2_f  <= r1_f;
            r2_d  <= r1_d;
            // 3: first two columns of Rx*Ry
            r3_p[0] <= r2_cb;
            r3_p[1] <= 32'(-rnd_shift(r2_m1, TRIG_FRAC));
            r3_p[2] <= 32'(rnd_shift(r2_m2, TRIG_FRAC));
            r3_q[0] <= '0;
            r3_q[1] <= r2_ca;
            r3_q[2] <= r2_sa;
            r3_cg   <= r2_cg;
            r3_sg   <= r2_sg;
            r3_f    <= r2_f;
            r3_d    <= r2_d;
            // 4: times Rz
            for (int i = 0; i < 3; i++) begin
                r4_pc[i] <= r3_p[i] * r3_cg;
                r4_qs[i] <= r3_q[i] * r3_sg;
                r4_qc[i] <= r3_q[i] * r3_cg;
                r4_ps[i] <= r3_p[i] * r3_sg;
            end
            r4_f <= r3_f;
            r4_d <= r3_d;
            // 5: rotation entries
            for (int i = 0; i < 3; i++) begin
                r5_r0[i] <= 34'(rnd_shift(r4_pc[i] + r4_qs[i], TRIG_FRAC));
                r5_r1[i] <= 34'(rnd_shift(r4_qc[i] - r4_ps[i], TRIG_FRAC));
            end
            r5_f <= r4_f;
            r5_d <= r4_d;
            // 6: centre offset products
            for (int i = 0; i < 3; i++) begin
                r6_wr[i] <= $signed({1'b0, w_w2}) * r5_r0[i];
                r6_hr[i] <= $signed({1'b0, w_h2}) * r5_r1[i];
                r6_r0[i] <= r5_r0[i];
                r6_r1[i] <= r5_r1[i];
            end
            r6_f <= r5_f;
            r6_d <= r5_d;
            // 7: R*A1 with translation
            for (int i = 0; i < 3; i++) begin
                r7_b[i][0] <= 48'(r6_r0[i]);
                r7_b[i][1] <= 48'(r6_r1[i]);
            end
            r7_b[0][2] <= -r6_wr[0] - r6_hr[0];
            r7_b[1][2] <= -r6_wr[1] - r6_hr[1];
            r7_b[2][2] <= -r6_wr[2] - r6_hr[2]
                          + ($signed({37'd0, r6_d}) <<< TRIG_FRAC);
            r7_f <= r6_f;
            // 8: intrinsic products
            for (int j = 0; j < 3; j++) begin
                r8_fa[j] <= $signed({1'b0, r7_f}) * r7_b[0][j];
                r8_wa[j] <= $signed({1'b0, w_w2}) * r7_b[2][j];
                r8_fb[j] <= $signed({1'b0, r7_f}) * r7_b[1][j];
                r8_hb[j] <= $signed({1'b0, w_h2}) * r7_b[2][j];
                r8_c[j]  <= 64'(r7_b[2][j]);
            end
            // 9: round, clamp
            r9_out.row0_col0 <= n_e[0][OUT_W:1];
            r9_out.row0_col1 <= n_e[1][OUT_W:1];
            r9_out.row0_col2 <= n_e[2][OUT_W:1];
            r9_out.row1_col0 <= n_e[3][OUT_W:1];
            r9_out.row1_col1 <= n_e[4][OUT_W:1];
            r9_out.row1_col2 <= n_e[5][OUT_W:1];
            r9_out.row2_col0 <= n_e[6][OUT_W:1];
            r9_out.row2_col1 <= n_e[7][OUT_W:1];
            r9_out.row2_col2 <= n_e[8][OUT_W:1];
            r9_out.saturated <= n_e[0][0] | n_e[1][0] | n_e[2][0] | n_e[3][0] | n_e[4][0]
                                | n_e[5][0] | n_e[6][0] | n_e[7][0] | n_e[8][0];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_e[j]     = finish(r8_fa[j] + r8_wa[j]);
            n_e[3 + j] = finish(r8_fb[j] + r8_hb[j]);
            n_e[6 + j] = finish(r8_c[j]);
        end
    end

    assign o_result.valid = r_vld[9];
    assign o_result.data  = r9_out;

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_vld[1])
        else $error("transfer did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=>
        (o_result.valid && $stable(o_result.data)))
        else $error("stalled result changed");

    a_sat_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[8] && w_adv && n_e[6][0]) |=> o_result.data.saturated)
        else $error("clamped entry without saturation flag");

endmodule
